/* sv/dif_pkg.sv */
`timescale 1ns / 1ps

package dif_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_DIGITS = 3'd1,
    ST_BAD_TERM  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_RANGE     = 3'd4
  } dif_status_t;

  // target width code, bits [2:1] of the mode
  typedef enum logic [1:0] {
    WD_8  = 2'd0,
    WD_16 = 2'd1,
    WD_32 = 2'd2,
    WD_64 = 2'd3
  } dif_width_t;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // overflow guard: one tenth of 2^64-1 and its last allowed digit
  localparam logic [63:0] U64_TENTH      = 64'd1844674407370955161;
  localparam logic [3:0]  U64_LAST_DIGIT = 4'd5;
  localparam logic [4:0]  MAX_DIGITS     = 5'd20;

  // parser state carried from word to word
  typedef struct packed {
    logic        active;
    logic [2:0]  ttype;
    logic        neg;
    logic [4:0]  cnt;
    logic [63:0] acc;
  } dif_state_t;

  // result of one step
  typedef struct packed {
    logic        emit;
    dif_status_t status;
    logic [63:0] value;
    logic [4:0]  length;
  } dif_result_t;

endpackage

/* sv/decimal_integer_field_parser.sv */
`timescale 1ns / 1ps

// channel  | handshake            | word
// ---------+----------------------+-----------------------------------------
// in       | in_valid / in_ready  | in_start_req, in_mode, in_character
// out      | out_valid / out_ready| out_status, out_value, out_length
//
// One character per cycle while the result register is free: each word waits
// in the input register, then one pass of the step logic (times-ten add and
// compares) updates the field state and may load the result register. A full,
// untaken result register stalls the input register, which holds its word;
// reset is synchronous and clears the field state to idle.

module decimal_integer_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_req,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_value,
  output logic [4:0]  out_length
);
  import dif_pkg::*;

  logic        in_valid_r;
  logic        in_start_r;
  logic [2:0]  in_mode_r;
  logic [7:0]  in_char_r;
  dif_state_t  st_r;
  dif_state_t  st_nxt;
  dif_result_t res;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [63:0] out_value_r;
  logic [4:0]  out_length_r;
  logic        advance;

  // the held word moves on when the result slot is free or being freed
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_start_r <= in_start_req;
      in_mode_r  <= in_mode;
      in_char_r  <= in_character;
    end
  end

  dif_step u_step (
    .st        (st_r),
    .start_req (in_start_r),
    .mode      (in_mode_r),
    .character (in_char_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // field state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && res.emit) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
      out_length_r <= res.length;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_length = out_length_r;

endmodule

/* sv/dif_step.sv */
`timescale 1ns / 1ps

module dif_step (
  input  dif_pkg::dif_state_t  st,
  input  logic                 start_req,
  input  logic [2:0]           mode,
  input  logic [7:0]           character,
  output dif_pkg::dif_state_t  st_nxt,
  output dif_pkg::dif_result_t res
);
  import dif_pkg::*;

  dif_state_t  eff;
  logic        is_digit;
  logic        is_term;
  logic [3:0]  dval;
  logic        ovf;
  logic        out_of_range;
  logic [63:0] acc_x10;
  logic [63:0] lim;

  // digit and terminator classification
  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign dval     = 4'(character - CH_ZERO);
  assign is_term  = (character == CH_NUL) || (character == CH_QUOTE) ||
                    (character == CH_COMMA) || (character == CH_RBRACK) ||
                    (character == CH_RBRACE);

  // state as seen by this word, with a start reopening the field
  always_comb begin
    eff = st;
    if (start_req) begin
      eff.active = 1'b1;
      eff.ttype  = mode;
      eff.neg    = 1'b0;
      eff.cnt    = '0;
      eff.acc    = '0;
    end
  end

  // multiply by ten as two shifts and an add
  assign acc_x10 = {eff.acc[60:0], 3'b000} + {eff.acc[62:0], 1'b0} + {60'd0, dval};

  assign ovf = (eff.cnt >= MAX_DIGITS) || (eff.acc > U64_TENTH) ||
               ((eff.acc == U64_TENTH) && (dval > U64_LAST_DIGIT));

  // range check against the target type
  always_comb begin
    lim          = '0;
    out_of_range = 1'b0;
    case (dif_width_t'(eff.ttype[2:1]))
      WD_8:    lim = 64'd1 << 7;
      WD_16:   lim = 64'd1 << 15;
      WD_32:   lim = 64'd1 << 31;
      WD_64:   lim = 64'd1 << 63;
      default: lim = 64'd1 << 63;
    endcase
    if (eff.ttype[0]) begin
      if (eff.neg) out_of_range = eff.acc > lim;
      else         out_of_range = eff.acc > (lim - 64'd1);
    end else if (dif_width_t'(eff.ttype[2:1]) != WD_64) begin
      out_of_range = eff.acc > ({lim[62:0], 1'b0} - 64'd1);
    end
  end

  // one step of the field parser
  always_comb begin
    st_nxt     = eff;
    res.emit   = 1'b0;
    res.status = ST_OK;
    res.value  = '0;
    res.length = '0;
    if (start_req && (character == CH_MINUS) && mode[0]) begin
      st_nxt.neg = 1'b1;
    end else if (eff.active) begin
      if (is_digit) begin
        if (ovf) begin
          res.emit      = 1'b1;
          res.status    = ST_OVERFLOW;
          st_nxt.active = 1'b0;
        end else begin
          st_nxt.acc = acc_x10;
          st_nxt.cnt = eff.cnt + 5'd1;
        end
      end else begin
        res.emit      = 1'b1;
        st_nxt.active = 1'b0;
        if (eff.cnt == 5'd0) begin
          res.status = ST_NO_DIGITS;
        end else if (!is_term) begin
          res.status = ST_BAD_TERM;
        end else if (out_of_range) begin
          res.status = ST_RANGE;
        end else begin
          res.status = ST_OK;
          res.value  = eff.neg ? (64'd0 - eff.acc) : eff.acc;
          res.length = eff.cnt + {4'd0, eff.neg};
        end
      end
    end
  end

endmodule

/* tb/sv/field_check_pkg.sv */
`timescale 1ns / 1ps

package field_check_pkg;

  import dif_pkg::*;

  // one expected field result
  typedef struct {
    dif_status_t status;
    logic [63:0] value;
    logic [4:0]  length;
  } field_result_t;

  class field_result_tracker;

    field_result_t awaited_results[$];
    int unsigned   mismatches;

    // running field state
    logic        open;
    logic [2:0]  ttype;
    logic        neg;
    logic [4:0]  cnt;
    logic [63:0] acc;

    function new();
      open       = 1'b0;
      ttype      = '0;
      neg        = 1'b0;
      cnt        = '0;
      acc        = '0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
    endtask

    // queue a result and go back to idle
    function void close_field(dif_status_t status, logic [63:0] value, logic [4:0] length);
      field_result_t r;
      r.status = status;
      r.value  = value;
      r.length = length;
      awaited_results.push_back(r);
      open = 1'b0;
    endfunction

    // advance the parse by one accepted word, returns 1 if the word was not ignored
    function bit take_char(logic start, logic [2:0] mode, logic [7:0] ch);
      logic [3:0]  digit;
      logic [63:0] cap;
      int unsigned bits;
      if (start) begin
        ttype = mode;
        acc   = '0;
        cnt   = '0;
        neg   = 1'b0;
        open  = 1'b1;
        // leading minus only opens a signed field
        if (ch == CH_MINUS && mode[0]) begin
          neg = 1'b1;
          return 1'b1;
        end
      end else if (!open) begin
        return 1'b0;
      end

      // digits accumulate, guarding the 64-bit magnitude and the run length
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        digit = 4'(ch - CH_ZERO);
        if (cnt >= MAX_DIGITS || acc > U64_TENTH ||
            (acc == U64_TENTH && digit > U64_LAST_DIGIT)) begin
          close_field(ST_OVERFLOW, '0, '0);
        end else begin
          acc = acc * 64'd10 + 64'(digit);
          cnt = cnt + 5'd1;
        end
        return 1'b1;
      end

      // any non-digit ends the field
      if (cnt == 0) begin
        close_field(ST_NO_DIGITS, '0, '0);
      end else if (!(ch inside {CH_NUL, CH_QUOTE, CH_COMMA, CH_RBRACK, CH_RBRACE})) begin
        close_field(ST_BAD_TERM, '0, '0);
      end else begin
        case (dif_width_t'(ttype[2:1]))
          WD_8:    bits = 8;
          WD_16:   bits = 16;
          WD_32:   bits = 32;
          default: bits = 64;
        endcase
        if (ttype[0]) begin
          cap = (64'd1 << (bits - 1)) - (neg ? 64'd0 : 64'd1);
        end else begin
          cap = (bits == 64) ? '1 : (64'd1 << bits) - 64'd1;
        end
        if (acc > cap) begin
          close_field(ST_RANGE, '0, '0);
        end else begin
          close_field(ST_OK, neg ? 64'd0 - acc : acc, cnt + 5'(neg));
        end
      end
      return 1'b1;
    endfunction

    // compare one result word with the oldest expectation
    task match_result(logic [2:0] status, logic [63:0] value, logic [4:0] length);
      field_result_t exp_r;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result: status %0d value 0x%h length %0d",
                         status, value, length));
        return;
      end
      exp_r = awaited_results.pop_front();
      if (status !== exp_r.status) begin
        report($sformatf("status %0d, wanted %s", status, exp_r.status.name()));
      end
      if (value !== exp_r.value) begin
        report($sformatf("value 0x%h, wanted 0x%h", value, exp_r.value));
      end
      if (length !== exp_r.length) begin
        report($sformatf("length %0d, wanted %0d", length, exp_r.length));
      end
    endtask

  endclass

endpackage

/* tb/sv/decimal_integer_field_parser_tb.sv */
`timescale 1ns / 1ps

module decimal_integer_field_parser_tb;

  import dif_pkg::*;
  import field_check_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1850;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_start_req = 1'b0;
  logic [2:0]  in_mode      = '0;
  logic [7:0]  in_character = '0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [63:0] out_value;
  logic [4:0]  out_length;

  field_result_tracker tracker;
  int unsigned         parsed_chars = 0;
  bit                  calm = 1'b0;

  decimal_integer_field_parser u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .in_mode      (in_mode),
    .in_character (in_character),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_value    (out_value),
    .out_length   (out_length)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check every word taken, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.match_result(out_status, out_value, out_length);
    end
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  // offer one character word and wait for it to be taken
  task automatic send_char(logic start, logic [2:0] mode, logic [7:0] ch);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_mode      <= mode;
    in_character <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tracker.take_char(start, mode, ch)) parsed_chars++;
  endtask

  // fixed text as one field, optionally closed by a nul
  task automatic send_text(logic [2:0] mode, string s, bit nul_end);
    for (int i = 0; i < s.len(); i++) send_char(i == 0, mode, s[i]);
    if (nul_end) send_char(1'b0, mode, CH_NUL);
  endtask

  // a mostly well-formed field with random type, sign, digits and end
  task automatic send_random_field();
    logic [7:0]  text[$];
    logic [2:0]  mode;
    logic [63:0] mag;
    logic [7:0]  term;
    string       digits;
    int unsigned bits;
    int unsigned k;
    mode = 3'($urandom_range(7));
    bits = 8 << mode[2:1];
    if (mode[0] ? ($urandom_range(1) == 1) : ($urandom_range(19) == 0)) begin
      text.push_back(CH_MINUS);
    end

    // digit run
    case ($urandom_range(10))
      0, 1: digits = $sformatf("%0d", $urandom_range(99));
      2, 3: begin
        mag    = {$urandom, $urandom} >> $urandom_range(63);
        digits = $sformatf("%0d", mag);
      end
      4, 5, 6: begin
        // around the type limits
        case ($urandom_range(2))
          0:       mag = (bits == 64) ? '1 : (64'd1 << bits) - 64'd1;
          1:       mag = 64'd1 << (bits - 1);
          default: mag = (64'd1 << (bits - 1)) - 64'd1;
        endcase
        mag    = mag + 64'($urandom_range(2)) - 64'd1;
        digits = $sformatf("%0d", mag);
      end
      7: digits = $sformatf("1844674407370955161%0d", $urandom_range(9));
      8: begin
        // leading zeros, long enough at times to hit the run limit
        digits = "";
        repeat ($urandom_range(15, 21)) digits = {digits, "0"};
        digits = {digits, $sformatf("%0d", $urandom_range(255))};
      end
      9: begin
        digits = "";
        repeat ($urandom_range(19, 23)) digits = {digits, $sformatf("%0d", $urandom_range(9))};
      end
      default: digits = "";
    endcase
    for (k = 0; k < digits.len(); k++) text.push_back(digits[k]);

    // closing byte: good terminator, any byte, or none at all
    k = $urandom_range(99);
    if (k < 75) begin
      case ($urandom_range(4))
        0:       term = CH_NUL;
        1:       term = CH_QUOTE;
        2:       term = CH_COMMA;
        3:       term = CH_RBRACK;
        default: term = CH_RBRACE;
      endcase
      text.push_back(term);
    end else if (k < 92) begin
      text.push_back(8'($urandom));
    end
    if (text.size() == 0) text.push_back(8'($urandom));

    foreach (text[i]) send_char(i == 0, (i == 0) ? mode : 3'($urandom), text[i]);
  endtask

  // loose words with stray starts
  task automatic send_noise();
    logic [7:0] ch;
    repeat ($urandom_range(1, 6)) begin
      ch = ($urandom_range(1) != 0) ? 8'(CH_ZERO + $urandom_range(9)) : 8'($urandom);
      send_char($urandom_range(3) == 0, 3'($urandom), ch);
    end
  endtask

  // stimulus and end of run
  initial begin
    int unsigned drain;
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed fields
    send_text(3'd0, "9}", 1'b0);
    send_text(3'd1, "-a", 1'b0);
    send_text(3'd2, "-", 1'b0);
    send_text(3'd3, "-0,", 1'b0);
    send_text(3'd7, "1-", 1'b0);
    send_text(3'd5, "--", 1'b0);
    send_char(1'b0, 3'd7, 8'hFF);
    send_text(3'd4, "7", 1'b0);
    send_text(3'd6, "3", 1'b0);
    send_char(1'b0, 3'd0, 8'hFF);
    send_text(3'd1, "128", 1'b1);
    send_text(3'd0, "5", 1'b1);
    send_text(3'd0, "255]", 1'b0);
    send_text(3'd6, "0\"", 1'b0);

    // random fields, with one long stretch free of gaps and stalls
    parsed_chars = 0;
    while (parsed_chars < RANDOM_CHARS) begin
      calm = (parsed_chars >= 700 && parsed_chars < 1000);
      if ($urandom_range(99) < 85) send_random_field();
      else send_noise();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain outstanding results
    drain = 0;
    while (tracker.awaited_results.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (tracker.awaited_results.size() != 0) begin
      tracker.report($sformatf("%0d results never arrived", tracker.awaited_results.size()));
    end

    if (tracker.mismatches == 0) begin
      $display("decimal_integer_field_parser verification clean");
    end else begin
      $display("decimal_integer_field_parser verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("decimal_integer_field_parser verification failed");
    $finish;
  end

endmodule
